// ----- sv/grmap_pkg.sv -----
`timescale 1ns / 1ps
package grmap_pkg;

   localparam int GRID_DIM_DEF      = 64;
   localparam int RAY_COUNT_DEF     = 360;
   localparam int MAX_RANGE_DEF     = 32;
   localparam int MAX_OBSTACLES_DEF = 128;

   localparam int FRAC_W = 15;
   localparam int TRIG_W = 17;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [5:0] RANGE_RESET = 6'd8;
   localparam logic CSR_IDX_RANGE = 1'b0;

   localparam logic [2:0] MAP_UNKNOWN  = 3'd0;
   localparam logic [2:0] MAP_FREE     = 3'd1;
   localparam logic [2:0] MAP_OBSTACLE = 3'd2;
   localparam logic [2:0] MAP_ROBOT    = 3'd3;
   localparam logic [2:0] MAP_FRONTIER = 3'd4;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SENSE,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OP,
      ST_RAY,
      ST_STEP,
      ST_LOOK,
      ST_MERGE,
      ST_ROBOT,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       we_truth;
      logic       we_owner;
      logic       we_map;
      logic       truth_d;
      logic [6:0] owner_d;
      logic [2:0] map_d;
   } mem_req_type;

endpackage

// ----- sv/grmap_trig_rom.sv -----
`timescale 1ns / 1ps
module grmap_trig_rom #(
   parameter int RAY_COUNT = grmap_pkg::RAY_COUNT_DEF,
   localparam int RAY_W = $clog2(RAY_COUNT)
) (
   input  logic                                clock,
   input  logic [RAY_W-1:0]                    ray_idx,
   output logic signed [grmap_pkg::TRIG_W-1:0] cos_q,
   output logic signed [grmap_pkg::TRIG_W-1:0] sin_q
);
   import grmap_pkg::*;

   typedef logic signed [TRIG_W-1:0] tab_type [RAY_COUNT];

   function automatic logic [63:0] to_q15(input logic [63:0] pos, input logic [63:0] neg);
      logic [63:0] v;
      v = (pos > neg) ? pos - neg : 64'd0;
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      return v;
   endfunction

   // Shift-and-subtract quotient, evaluated only while the table is built.
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo, rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave Taylor series in Q2.30, folded out to the full circle.
   function automatic tab_type build_tab(input logic want_sin);
      tab_type     t;
      logic [63:0] q, r, theta, cp, cn, sp, sn, term, c, s, cv, sv;
      logic        done;
      for (int i = 0; i < RAY_COUNT; i++) begin
         q = udiv(64'(4 * i), 64'(RAY_COUNT));
         r = 64'(4 * i) - q * 64'(RAY_COUNT);
         theta = udiv(HALF_PI_Q30 * r, 64'(RAY_COUNT));
         cp = 64'd1 << 30; cn = 0; sp = 0; sn = 0; term = 64'd1 << 30;
         done = 1'b0;
         for (int k = 1; k <= 30; k++) begin
            if (!done) begin
               term = udiv((term * theta) >> 30, 64'(k));
               if (term == 0) begin
                  done = 1'b1;
               end else if (k[0]) begin
                  if (k[1]) sn = sn + term; else sp = sp + term;
               end else begin
                  if (k[1]) cn = cn + term; else cp = cp + term;
               end
            end
         end
         c = to_q15(cp, cn);
         s = to_q15(sp, sn);
         case (q[1:0])
            2'd0: begin cv = c; sv = s; end
            2'd1: begin cv = 64'd0 - s; sv = c; end
            2'd2: begin cv = 64'd0 - c; sv = 64'd0 - s; end
            default: begin cv = s; sv = 64'd0 - c; end
         endcase
         t[i] = want_sin ? TRIG_W'(sv) : TRIG_W'(cv);
      end
      return t;
   endfunction

   localparam tab_type COS_TAB = build_tab(1'b0);
   localparam tab_type SIN_TAB = build_tab(1'b1);

   always_ff @(posedge clock) begin
      cos_q <= COS_TAB[ray_idx];
      sin_q <= SIN_TAB[ray_idx];
   end

endmodule

// ----- sv/grmap_grid_mem.sv -----
`timescale 1ns / 1ps
module grmap_grid_mem #(
   parameter int GRID_DIM = grmap_pkg::GRID_DIM_DEF,
   localparam int DEPTH = GRID_DIM * GRID_DIM,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic [IDX_W-1:0]       addr,
   input  grmap_pkg::mem_req_type req,
   output logic                   truth_q,
   output logic [6:0]             owner_q,
   output logic [2:0]             map_q
);
   import grmap_pkg::*;

   logic       truth_mem [DEPTH];
   logic [6:0] owner_mem [DEPTH];
   logic [2:0] map_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (req.we_truth) truth_mem[addr] <= req.truth_d;
      if (req.we_owner) owner_mem[addr] <= req.owner_d;
      if (req.we_map) map_mem[addr] <= req.map_d;
      truth_q <= truth_mem[addr];
      owner_q <= owner_mem[addr];
      map_q   <= map_mem[addr];
   end

endmodule

// ----- sv/grmap_seq.sv -----
`timescale 1ns / 1ps
module grmap_seq #(
   parameter int GRID_DIM      = grmap_pkg::GRID_DIM_DEF,
   parameter int RAY_COUNT     = grmap_pkg::RAY_COUNT_DEF,
   parameter int MAX_RANGE     = grmap_pkg::MAX_RANGE_DEF,
   parameter int MAX_OBSTACLES = grmap_pkg::MAX_OBSTACLES_DEF,
   localparam int DEPTH = GRID_DIM * GRID_DIM,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int RAY_W = $clog2(RAY_COUNT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic [5:0]                          req_cell_x,
   input  logic [5:0]                          req_cell_y,
   input  logic                                req_occupied,
   input  logic [6:0]                          req_obstacle_id,
   input  logic [2:0]                          req_map_value,
   input  logic [5:0]                          range_steps,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_cell_value,
   output logic [12:0]                         rsp_cells_mapped,
   output logic [7:0]                          rsp_obst_count,
   output logic [RAY_W-1:0]                    ray_idx,
   input  logic signed [grmap_pkg::TRIG_W-1:0] cos_q,
   input  logic signed [grmap_pkg::TRIG_W-1:0] sin_q,
   output logic [IDX_W-1:0]                    mem_addr,
   output grmap_pkg::mem_req_type              mem_req,
   input  logic                                truth_q,
   input  logic [6:0]                          owner_q,
   input  logic [2:0]                          map_q
);
   import grmap_pkg::*;

   localparam int GRID_W    = $clog2(GRID_DIM);
   localparam int RANGE_W   = $clog2(MAX_RANGE + 1);
   localparam int OBS_W     = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int POS_W     = GRID_W + RANGE_W + FRAC_W + 2;
   localparam int CRD_W     = POS_W - FRAC_W;
   localparam int MAP_LIMIT = (DEPTH < 8191) ? DEPTH : 8191;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [5:0]              x_ff, x_in, y_ff, y_in;
   logic                    occ_ff, occ_in;
   logic [6:0]              oid_ff, oid_in;
   logic [2:0]              mv_ff, mv_in;
   logic [RAY_W-1:0]        ray_ff, ray_in;
   logic [RANGE_W-1:0]      j_ff, j_in, steps_ff, steps_in;
   logic signed [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [IDX_W-1:0]        cell_ff, cell_in, clr_ff, clr_in;
   logic [OBS_W-1:0]        mk_ff, mk_in;
   logic                    touched_ff [MAX_OBSTACLES];
   logic                    touched_in [MAX_OBSTACLES];
   logic                    seen_ff [MAX_OBSTACLES];
   logic                    seen_in [MAX_OBSTACLES];
   logic [12:0]             mapped_ff, mapped_in;
   logic [7:0]              seen_cnt_ff, seen_cnt_in;

   logic signed [CRD_W-1:0] fx, fy;
   logic                    in_grid, step_in_grid, last_ray;
   logic [IDX_W-1:0]        cmd_idx, step_idx;

   assign fx = px_ff[POS_W-1:FRAC_W];
   assign fy = py_ff[POS_W-1:FRAC_W];
   assign step_in_grid = !fx[CRD_W-1] && !fy[CRD_W-1] &&
                         (int'(fx) < GRID_DIM) && (int'(fy) < GRID_DIM);
   assign step_idx = IDX_W'(int'(fx) * GRID_DIM + int'(fy));
   assign in_grid  = (int'(x_ff) < GRID_DIM) && (int'(y_ff) < GRID_DIM);
   assign cmd_idx  = IDX_W'(int'(x_ff) * GRID_DIM + int'(y_ff));
   assign last_ray = (int'(ray_ff) == RAY_COUNT - 1);

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_cell_value   = in_grid ? map_q : MAP_UNKNOWN;
   assign rsp_cells_mapped = mapped_ff;
   assign rsp_obst_count   = seen_cnt_ff;
   assign ray_idx          = ray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         mapped_ff   <= '0;
         seen_cnt_ff <= '0;
         for (int i = 0; i < MAX_OBSTACLES; i++) begin
            touched_ff[i] <= 1'b0;
            seen_ff[i]    <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         mapped_ff   <= mapped_in;
         seen_cnt_ff <= seen_cnt_in;
         touched_ff  <= touched_in;
         seen_ff     <= seen_in;
      end
      cmd_ff   <= cmd_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      occ_ff   <= occ_in;
      oid_ff   <= oid_in;
      mv_ff    <= mv_in;
      ray_ff   <= ray_in;
      j_ff     <= j_in;
      steps_ff <= steps_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      cell_ff  <= cell_in;
      mk_ff    <= mk_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      occ_in      = occ_ff;
      oid_in      = oid_ff;
      mv_in       = mv_ff;
      ray_in      = ray_ff;
      j_in        = j_ff;
      steps_in    = steps_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      cell_in     = cell_ff;
      clr_in      = clr_ff;
      mk_in       = mk_ff;
      touched_in  = touched_ff;
      seen_in     = seen_ff;
      mapped_in   = mapped_ff;
      seen_cnt_in = seen_cnt_ff;
      mem_addr    = cmd_idx;
      mem_req     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_addr         = clr_ff;
            mem_req.we_truth = 1'b1;
            mem_req.we_map   = 1'b1;
            mem_req.map_d    = MAP_UNKNOWN;
            clr_in           = clr_ff + 1'b1;
            if (int'(clr_ff) == DEPTH - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_cmd);
               x_in     = req_cell_x;
               y_in     = req_cell_y;
               occ_in   = req_occupied;
               oid_in   = req_obstacle_id;
               mv_in    = req_map_value;
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            state_in = ST_READ;
            case (cmd_ff)
               CMD_LOAD: begin
                  mem_req.we_truth = in_grid;
                  mem_req.truth_d  = occ_ff;
                  mem_req.we_owner = in_grid && occ_ff;
                  mem_req.owner_d  = oid_ff;
               end
               CMD_WRITE: begin
                  mem_req.we_map = in_grid && (mv_ff <= MAP_FRONTIER);
                  mem_req.map_d  = mv_ff;
               end
               CMD_SENSE: begin
                  if (in_grid) begin
                     ray_in   = '0;
                     steps_in = (int'(range_steps) < MAX_RANGE) ?
                                RANGE_W'(range_steps) : RANGE_W'(MAX_RANGE);
                     for (int i = 0; i < MAX_OBSTACLES; i++) touched_in[i] = 1'b0;
                     state_in = ST_RAY;
                  end
               end
               default: ;
            endcase
         end
         ST_RAY: begin
            px_in    = POS_W'($signed({1'b0, x_ff, {FRAC_W{1'b0}}}));
            py_in    = POS_W'($signed({1'b0, y_ff, {FRAC_W{1'b0}}}));
            j_in     = '0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            mem_addr = step_idx;
            cell_in  = step_idx;
            if ((j_ff == steps_ff) || !step_in_grid) begin
               if (last_ray) begin
                  mk_in    = '0;
                  state_in = ST_MERGE;
               end else begin
                  ray_in   = ray_ff + 1'b1;
                  state_in = ST_RAY;
               end
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            mem_addr       = cell_ff;
            mem_req.we_map = 1'b1;
            if (truth_q) begin
               mem_req.map_d = MAP_OBSTACLE;
               if (int'(owner_q) < MAX_OBSTACLES) touched_in[OBS_W'(owner_q)] = 1'b1;
               if (last_ray) begin
                  mk_in    = '0;
                  state_in = ST_MERGE;
               end else begin
                  ray_in   = ray_ff + 1'b1;
                  state_in = ST_RAY;
               end
            end else begin
               mem_req.map_d = MAP_FREE;
               if ((map_q == MAP_UNKNOWN || map_q == MAP_FRONTIER) &&
                   (mapped_ff < 13'(MAP_LIMIT))) begin
                  mapped_in = mapped_ff + 1'b1;
               end
               // The position walks by one table step per ray step.
               px_in    = px_ff + POS_W'(cos_q);
               py_in    = py_ff + POS_W'(sin_q);
               j_in     = j_ff + 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_MERGE: begin
            if (touched_ff[mk_ff] && !seen_ff[mk_ff]) begin
               seen_in[mk_ff] = 1'b1;
               if (seen_cnt_ff != 8'hFF) seen_cnt_in = seen_cnt_ff + 1'b1;
            end
            mk_in = mk_ff + 1'b1;
            if (int'(mk_ff) == MAX_OBSTACLES - 1) state_in = ST_ROBOT;
         end
         ST_ROBOT: begin
            mem_req.we_map = 1'b1;
            mem_req.map_d  = MAP_ROBOT;
            state_in       = ST_READ;
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/grid_ray_cast_mapper_core.sv -----
`timescale 1ns / 1ps
// Simulated range sensor and occupancy map on a square grid.
// Command channel: an item is taken at a rising edge with start high and busy
// low. cmd selects load truth cell, sense at position, write map cell or read
// map cell. Every item gives exactly one result: rsp_valid is high for one
// cycle with the map cell after the command and the two running counters.
// The receiver cannot hold results off; busy stays high until the result
// cycle is over, so no second item enters meanwhile.
// Load, write and read pass through ST_OP, ST_READ and ST_RESP after the
// accept, and the next item can be taken once the block is idle again.
// When its position lies in the grid, a sense decodes its command, then casts
// RAY_COUNT rays one after another through one step unit and the single grid
// memory port: each ray alternates ST_STEP and ST_LOOK up to the range steps
// (fewer when it stops early), then the touched flags of the MAX_OBSTACLES
// obstacles are merged one by one, then ST_ROBOT, ST_READ and ST_RESP follow.
// After reset a clearing pass over all GRID_DIM*GRID_DIM cells (4096) sets the
// truth grid free and the map unknown; busy is high during it. The APB port
// holds the sensor range at address 0; a sense takes its value when it starts.
module grid_ray_cast_mapper_core #(
   parameter int GRID_DIM      = grmap_pkg::GRID_DIM_DEF,
   parameter int RAY_COUNT     = grmap_pkg::RAY_COUNT_DEF,
   parameter int MAX_RANGE     = grmap_pkg::MAX_RANGE_DEF,
   parameter int MAX_OBSTACLES = grmap_pkg::MAX_OBSTACLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic        req_occupied,
   input  logic [6:0]  req_obstacle_id,
   input  logic [2:0]  req_map_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_cell_value,
   output logic [12:0] rsp_cells_mapped,
   output logic [7:0]  rsp_obst_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import grmap_pkg::*;

   localparam int IDX_W = $clog2(GRID_DIM * GRID_DIM);
   localparam int RAY_W = $clog2(RAY_COUNT);

   logic [5:0]               range_ff;
   logic [RAY_W-1:0]         ray_idx;
   logic signed [TRIG_W-1:0] cos_q, sin_q;
   logic [IDX_W-1:0]         mem_addr;
   mem_req_type              mem_req;
   logic                     truth_q;
   logic [6:0]               owner_q;
   logic [2:0]               map_q;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_RANGE) ? {26'd0, range_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RESET;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == CSR_IDX_RANGE)) begin
         range_ff <= pwdata[5:0];
      end
   end

   grmap_trig_rom #(.RAY_COUNT(RAY_COUNT)) u_rom (
      .clock   (clock),
      .ray_idx (ray_idx),
      .cos_q   (cos_q),
      .sin_q   (sin_q)
   );

   grmap_grid_mem #(.GRID_DIM(GRID_DIM)) u_mem (
      .clock   (clock),
      .addr    (mem_addr),
      .req     (mem_req),
      .truth_q (truth_q),
      .owner_q (owner_q),
      .map_q   (map_q)
   );

   grmap_seq #(
      .GRID_DIM      (GRID_DIM),
      .RAY_COUNT     (RAY_COUNT),
      .MAX_RANGE     (MAX_RANGE),
      .MAX_OBSTACLES (MAX_OBSTACLES)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_occupied     (req_occupied),
      .req_obstacle_id  (req_obstacle_id),
      .req_map_value    (req_map_value),
      .range_steps      (range_ff),
      .rsp_valid        (rsp_valid),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_cells_mapped (rsp_cells_mapped),
      .rsp_obst_count   (rsp_obst_count),
      .ray_idx          (ray_idx),
      .cos_q            (cos_q),
      .sin_q            (sin_q),
      .mem_addr         (mem_addr),
      .mem_req          (mem_req),
      .truth_q          (truth_q),
      .owner_q          (owner_q),
      .map_q            (map_q)
   );

endmodule

// ----- sv/grmap_checker.sv -----
`timescale 1ns / 1ps
module grmap_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // The clearing pass keeps the block busy right after reset.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_result_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind grid_ray_cast_mapper_core grmap_checker u_grmap_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
